// ===== src/pst_pkg.sv =====
`default_nettype none
package pst_pkg;

  // Slot table and tick rate.
  localparam int SLOTS            = 8;
  localparam int TICKS_PER_SECOND = 1000;
  localparam int MS_PER_SECOND    = 1000;

  // Derived widths.
  localparam int SUB_W   = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam int TPS_W   = $clog2(TICKS_PER_SECOND + 1);
  localparam int PROD_W  = 32 + TPS_W;
  localparam int MASK_W  = 8;
  localparam int SLOTF_W = 3;

  // When the tick rate is a whole multiple of 1000, ms to ticks is one multiply.
  localparam bit RATIO_EXACT = (TICKS_PER_SECOND % MS_PER_SECOND) == 0;
  localparam int TPS_RATIO   = TICKS_PER_SECOND / MS_PER_SECOND;

  // Divide by 1000 for the other rates. Any product at or above 1000 * 2^32
  // saturates, so the dividend fits in 42 bits. The high part from bit 21 up
  // is folded back as 2^21 = 2097 * 1000 + 152, which leaves a 29-bit
  // remainder term that is divided by 8 and then by 125 with a reciprocal.
  localparam int          DIV_W     = 42;
  localparam int          DIV_XW    = (PROD_W > DIV_W) ? PROD_W : DIV_W;
  localparam logic [63:0] DIV_LIMIT = 64'(MS_PER_SECOND) << 32;
  localparam int          DIV_SPLIT = 21;
  localparam int          DIV_HI_Q  = (1 << DIV_SPLIT) / MS_PER_SECOND;
  localparam int          DIV_HI_R  = (1 << DIV_SPLIT) % MS_PER_SECOND;
  localparam int          DIV_Q_W   = 33;
  localparam int          DIV_Z_W   = 29;
  localparam int          DIV_ZP_W  = 53;
  localparam int          DIV_SH    = 33;
  localparam logic [31:0] DIV_RECIP = 32'(((64'd1 << DIV_SH) + 64'(MS_PER_SECOND / 8 - 1))
                                          / 64'(MS_PER_SECOND / 8));

  // Action codes.
  localparam logic [1:0] ACT_TICK      = 2'd0;
  localparam logic [1:0] ACT_INSTALL   = 2'd1;
  localparam logic [1:0] ACT_UNINSTALL = 2'd2;

  // Install status codes.
  localparam logic STS_OK      = 1'b0;
  localparam logic STS_NO_SLOT = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_CONV
  } pst_state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] period_ms;
    logic [2:0]  slot_id;
  } pst_in_t;

  typedef struct packed {
    logic [MASK_W-1:0]  fired_mask;
    logic [SLOTF_W-1:0] slot;
    logic               status;
    logic [63:0]        tick_total;
    logic [63:0]        seconds_total;
  } pst_out_t;

  // Command broadcast to every slot cell.
  typedef struct packed {
    logic tick;
    logic install;
  } pst_cmd_t;

endpackage
`default_nettype wire

// ===== src/pst_cell.sv =====
`default_nettype none
module pst_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pst_pkg::pst_cmd_t cmd,
  input  wire logic              drop,
  input  wire logic [63:0]       tick_now,
  input  wire logic [63:0]       tick_after,
  input  wire logic [31:0]       period_in,
  input  wire logic              claim_in,
  output logic                   claim_out,
  output logic                   grant,
  output logic                   fire
);
  import pst_pkg::*;

  logic        active_r, active_nxt;
  logic [31:0] period_r, period_nxt;
  logic [63:0] deadline_r, deadline_nxt;

  // The install claim ripples past occupied cells to the lowest free one.
  assign grant     = cmd.install & claim_in & ~active_r;
  assign claim_out = claim_in & active_r;

  // A tick fires an armed slot whose deadline has been reached.
  assign fire = cmd.tick & active_r & (deadline_r <= tick_after);

  always_comb begin
    active_nxt   = active_r;
    period_nxt   = period_r;
    deadline_nxt = deadline_r;
    if (fire) begin
      deadline_nxt = tick_after + {32'd0, period_r};
    end else if (grant) begin
      active_nxt   = 1'b1;
      period_nxt   = period_in;
      deadline_nxt = tick_now + {32'd0, period_in};
    end else if (drop) begin
      active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    period_r   <= period_nxt;
    deadline_r <= deadline_nxt;
  end

endmodule
`default_nettype wire

// ===== src/pst_conv.sv =====
`default_nettype none
module pst_conv (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] ms,
  output logic             done,
  output logic [31:0]      ticks
);
  import pst_pkg::*;

  logic [PROD_W-1:0] quot;

  generate
    if (RATIO_EXACT) begin : g_exact
      logic              done_r;
      logic [PROD_W-1:0] prod_r;

      // Whole ticks per millisecond: a single constant multiply.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          prod_r <= PROD_W'(ms) * PROD_W'(TPS_RATIO);
        end
      end

      assign done = done_r;
      assign quot = prod_r;
    end else begin : g_div
      logic                v1_r;
      logic                v2_r;
      logic                done_r;
      logic                sat_r;
      logic [DIV_XW-1:0]   prod;
      logic [DIV_W-1:0]    x_r;
      logic [DIV_Q_W-1:0]  qh_r;
      logic [DIV_Z_W-1:0]  z_r;
      logic [DIV_ZP_W-1:0] zprod;
      logic [DIV_Q_W-1:0]  q_r;

      // Three stages: the product, the fold of its high part, and the
      // reciprocal multiply of the remaining term.
      assign prod  = DIV_XW'(ms) * DIV_XW'(TICKS_PER_SECOND);
      assign zprod = DIV_ZP_W'(z_r[DIV_Z_W-1:3]) * DIV_ZP_W'(DIV_RECIP);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v1_r   <= 1'b0;
          v2_r   <= 1'b0;
          done_r <= 1'b0;
        end else begin
          v1_r   <= start;
          v2_r   <= v1_r;
          done_r <= v2_r;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          sat_r <= prod >= DIV_XW'(DIV_LIMIT);
          x_r   <= prod[DIV_W-1:0];
        end
        if (v1_r) begin
          qh_r <= DIV_Q_W'(x_r[DIV_W-1:DIV_SPLIT]) * DIV_Q_W'(DIV_HI_Q);
          z_r  <= DIV_Z_W'(x_r[DIV_W-1:DIV_SPLIT]) * DIV_Z_W'(DIV_HI_R)
                  + DIV_Z_W'(x_r[DIV_SPLIT-1:0]);
        end
        if (v2_r) begin
          q_r <= qh_r + DIV_Q_W'(zprod[DIV_ZP_W-1:DIV_SH]);
        end
      end

      assign done = done_r;
      assign quot = sat_r ? '1 : PROD_W'(q_r);
    end
  endgenerate

  // Periods that do not fit in 32 bits saturate.
  assign ticks = (|quot[PROD_W-1:32]) ? 32'hFFFF_FFFF : quot[31:0];

endmodule
`default_nettype wire

// ===== src/periodic_slot_timer.sv =====
`default_nettype none
// Periodic slot timer: a 64-bit tick counter, a 64-bit seconds counter that
// advances every TICKS_PER_SECOND ticks, and a row of SLOTS timer cells. Each
// cell holds one slot's active flag, period and deadline, and all cells check
// their deadline against the new tick count at once. A tick, an uninstall or
// an unused action code is handled straight from ST_IDLE; an install waits
// in ST_CONV for the period conversion. While the tick rate is a whole
// multiple of 1000 per second, one registered multiply converts milliseconds
// to ticks; otherwise the three-stage divide by 1000 in the conversion unit
// does it. One item is in flight at a time; a two-entry result buffer lets the
// next item be accepted while an earlier result still waits for its transfer.
module periodic_slot_timer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pst_pkg::pst_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pst_pkg::pst_out_t      out_data
);
  import pst_pkg::*;

  pst_state_t state_r, state_nxt;

  logic [63:0]      tick_r, tick_nxt;
  logic [63:0]      tick_inc_r, tick_inc_nxt;
  logic [SUB_W-1:0] sub_r, sub_nxt;
  logic [63:0]      sec_r, sec_nxt;

  logic      head_v_r, head_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  pst_out_t  head_r, head_nxt;
  pst_out_t  skid_r, skid_nxt;

  logic      in_xfer;
  logic      pop;
  logic      push;
  pst_out_t  push_data;

  logic      conv_start;
  logic      conv_done;
  logic [31:0] conv_ticks;

  pst_cmd_t           cmd;
  logic [SLOTS-1:0]   drop;
  logic [SLOTS:0]     claim;
  logic [SLOTS-1:0]   grant;
  logic [SLOTS-1:0]   fire;
  logic [MASK_W-1:0]  mask;
  logic [SLOTF_W-1:0] slot_enc;

  assign in_ready  = (state_r == ST_IDLE) && !skid_v_r;
  assign in_xfer   = in_valid && in_ready;
  assign pop       = head_v_r && out_ready;
  assign out_valid = head_v_r;
  assign out_data  = head_r;

  assign conv_start  = in_xfer && (in_data.action == ACT_INSTALL);
  assign cmd.tick    = in_xfer && (in_data.action == ACT_TICK);
  assign cmd.install = (state_r == ST_CONV) && conv_done;

  pst_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .ms    (in_data.period_ms),
    .done  (conv_done),
    .ticks (conv_ticks)
  );

  // Row of slot cells; the install claim enters at slot 0.
  assign claim[0] = 1'b1;

  generate
    for (genvar i = 0; i < SLOTS; i++) begin : g_slot
      assign drop[i] = in_xfer && (in_data.action == ACT_UNINSTALL)
                       && (32'(in_data.slot_id) == i);

      pst_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .drop       (drop[i]),
        .tick_now   (tick_r),
        .tick_after (tick_inc_r),
        .period_in  (conv_ticks),
        .claim_in   (claim[i]),
        .claim_out  (claim[i+1]),
        .grant      (grant[i]),
        .fire       (fire[i])
      );
    end
  endgenerate

  // Only slots 0 to 7 are visible in the fire mask; the slot field keeps
  // the low bits of the slot number.
  always_comb begin
    mask     = '0;
    slot_enc = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (i < MASK_W) begin
        mask[i] = fire[i];
      end
      if (grant[i]) begin
        slot_enc = SLOTF_W'(i);
      end
    end
  end

  // Tick, sub-second and seconds counters.
  always_comb begin
    tick_nxt     = tick_r;
    tick_inc_nxt = tick_inc_r;
    sub_nxt      = sub_r;
    sec_nxt      = sec_r;
    if (cmd.tick) begin
      tick_nxt     = tick_inc_r;
      tick_inc_nxt = tick_inc_r + 64'd1;
      if (sub_r == SUB_W'(TICKS_PER_SECOND - 1)) begin
        sub_nxt = '0;
        sec_nxt = sec_r + 64'd1;
      end else begin
        sub_nxt = sub_r + SUB_W'(1);
      end
    end
  end

  // Sequencer: installs wait in ST_CONV for the period conversion.
  always_comb begin
    state_nxt = state_r;
    push      = 1'b0;
    push_data = '{fired_mask: '0, slot: '0, status: STS_OK,
                  tick_total: tick_nxt, seconds_total: sec_nxt};
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data.action == ACT_INSTALL) begin
            state_nxt = ST_CONV;
          end else begin
            push                 = 1'b1;
            push_data.fired_mask = mask;
          end
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_nxt = ST_IDLE;
          push      = 1'b1;
          if (claim[SLOTS]) begin
            push_data.status = STS_NO_SLOT;
          end else begin
            push_data.slot = slot_enc;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Two-entry result buffer: a new result lands in the head when it frees up,
  // otherwise in the skid entry.
  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (pop) begin
        head_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!head_v_r || pop) begin
        head_nxt   = push_data;
        head_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_data;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      head_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      tick_r     <= '0;
      tick_inc_r <= 64'd1;
      sub_r      <= '0;
      sec_r      <= '0;
      head_v_r   <= 1'b0;
      skid_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      tick_r     <= tick_nxt;
      tick_inc_r <= tick_inc_nxt;
      sub_r      <= sub_nxt;
      sec_r      <= sec_nxt;
      head_v_r   <= head_v_nxt;
      skid_v_r   <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule
`default_nettype wire

// ===== sim/tb_periodic_slot_timer.sv =====
`default_nettype none
module tb_periodic_slot_timer;
  import pst_pkg::*;

  // The one action code that the block leaves without a meaning.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTED = 40;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  pst_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pst_out_t out_data;

  // Idle and stall rates in percent for the current phase.
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  int mismatch_count = 0;
  int result_count = 0;
  int cycle_count = 0;

  // Results that the timer owes, oldest first.
  pst_out_t pending_results[$];

  // Shadow copy of the timer state.
  logic [63:0]      mdl_ticks = '0;
  int               mdl_subsec = 0;
  logic [63:0]      mdl_seconds = '0;
  logic [SLOTS-1:0] mdl_active = '0;
  logic [31:0]      mdl_period[SLOTS];
  logic [63:0]      mdl_deadline[SLOTS];

  periodic_slot_timer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
               pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Updates the shadow state for one item and returns the result it must produce.
  function automatic pst_out_t timer_next_result(input pst_in_t item);
    pst_out_t    r;
    logic [63:0] conv;
    logic        found;
    int          i;
    r = '0;
    found = 1'b0;
    case (item.action)
      ACT_TICK: begin
        mdl_ticks = mdl_ticks + 64'd1;
        if (mdl_subsec + 1 >= TICKS_PER_SECOND) begin
          mdl_subsec = 0;
          mdl_seconds = mdl_seconds + 64'd1;
        end else begin
          mdl_subsec = mdl_subsec + 1;
        end
        // Every active slot at or past its deadline fires and re-arms.
        for (i = 0; i < SLOTS; i++) begin
          if (mdl_active[i] && mdl_ticks >= mdl_deadline[i]) begin
            if (i < MASK_W) r.fired_mask[i] = 1'b1;
            mdl_deadline[i] = mdl_ticks + {32'd0, mdl_period[i]};
          end
        end
      end
      ACT_INSTALL: begin
        r.status = STS_NO_SLOT;
        // The lowest free slot is taken; the period saturates at 32 bits.
        for (i = 0; i < SLOTS; i++) begin
          if (!found && !mdl_active[i]) begin
            found = 1'b1;
            conv = {32'd0, item.period_ms} * 64'(TICKS_PER_SECOND) / 64'(MS_PER_SECOND);
            if (conv > 64'hFFFF_FFFF) conv = 64'hFFFF_FFFF;
            mdl_active[i] = 1'b1;
            mdl_period[i] = conv[31:0];
            mdl_deadline[i] = mdl_ticks + conv;
            r.slot = SLOTF_W'(i);
            r.status = STS_OK;
          end
        end
      end
      ACT_UNINSTALL: begin
        if (item.slot_id < SLOTS) mdl_active[item.slot_id] = 1'b0;
      end
      default: begin
      end
    endcase
    r.tick_total = mdl_ticks;
    r.seconds_total = mdl_seconds;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("Mismatch on result %0d, %s: got %0h, expected %0h", result_count, what,
               got, want);
    mismatch_count++;
  endtask

  // The receiver stalls at random at the current phase's rate.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Each result transfer is checked against the oldest owed result.
  always @(posedge clk) begin
    pst_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.tick_total, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.fired_mask !== want.fired_mask)
          report_mismatch("fired_mask", 64'(out_data.fired_mask), 64'(want.fired_mask));
        if (out_data.slot !== want.slot)
          report_mismatch("slot", 64'(out_data.slot), 64'(want.slot));
        if (out_data.status !== want.status)
          report_mismatch("status", 64'(out_data.status), 64'(want.status));
        if (out_data.tick_total !== want.tick_total)
          report_mismatch("tick_total", out_data.tick_total, want.tick_total);
        if (out_data.seconds_total !== want.seconds_total)
          report_mismatch("seconds_total", out_data.seconds_total, want.seconds_total);
      end
      result_count++;
    end
  end

  // Offers one item from a falling edge and returns at the falling edge after its transfer.
  task automatic send_item(input logic [1:0] action, input logic [31:0] ms,
                           input logic [2:0] id);
    pst_in_t item;
    item.action = action;
    item.period_ms = ms;
    item.slot_id = id;
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(timer_next_result(item));
    @(negedge clk);
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Unused action code, a lone tick, and uninstall of a free slot, with extreme field values.
  task automatic test_unused_and_extremes();
    send_item(ACT_TICK, 32'hFFFF_FFFF, 3'd7);
    send_item(ACT_UNUSED, 32'hFFFF_FFFF, 3'd7);
    send_item(ACT_UNUSED, 32'd0, 3'd0);
    send_item(ACT_UNINSTALL, 32'd0, 3'd5);
    pause_until_drained();
  endtask

  // Fill every slot, including zero and maximum periods, then overflow the table and tick.
  task automatic test_table_fill_and_overflow();
    send_item(ACT_INSTALL, 32'd0, 3'd0);
    send_item(ACT_INSTALL, 32'd1, 3'd0);
    send_item(ACT_INSTALL, 32'd2, 3'd0);
    send_item(ACT_INSTALL, 32'hFFFF_FFFF, 3'd0);
    send_item(ACT_INSTALL, 32'd3, 3'd0);
    send_item(ACT_INSTALL, 32'h8000_0000, 3'd0);
    send_item(ACT_INSTALL, 32'd7, 3'd0);
    send_item(ACT_INSTALL, 32'd0, 3'd0);
    send_item(ACT_INSTALL, 32'd5, 3'd0);
    repeat (4) send_item(ACT_TICK, 32'd0, 3'd0);
    pause_until_drained();
  endtask

  // Free slots twice over and reuse them at the low and high end of the table.
  task automatic test_uninstall_cases();
    send_item(ACT_UNINSTALL, 32'd0, 3'd7);
    send_item(ACT_UNINSTALL, 32'd0, 3'd7);
    send_item(ACT_UNINSTALL, 32'd0, 3'd0);
    send_item(ACT_INSTALL, 32'h5555_5555, 3'd0);
    send_item(ACT_INSTALL, 32'hAAAA_AAAA, 3'd0);
    send_item(ACT_TICK, 32'd0, 3'd0);
    send_item(ACT_UNINSTALL, 32'd0, 3'd3);
    pause_until_drained();
  endtask

  // Mostly ticks with installs of short periods and uninstalls, some noise on every field.
  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_pct);
    int          roll;
    logic [1:0]  action;
    logic [31:0] ms;
    src_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      ms = $urandom;
      if (roll < 62) begin
        action = ACT_TICK;
      end else if (roll < 78) begin
        action = ACT_INSTALL;
        roll = $urandom_range(0, 99);
        if (roll < 70) ms = $urandom_range(0, 40);
        else if (roll < 85) ms = $urandom_range(0, 1500);
      end else if (roll < 95) begin
        action = ACT_UNINSTALL;
      end else begin
        action = ACT_UNUSED;
      end
      send_item(action, ms, 3'($urandom_range(0, 7)));
    end
    pause_until_drained();
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      mdl_period[i] = '0;
      mdl_deadline[i] = '0;
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_unused_and_extremes();
    test_table_fill_and_overflow();
    test_uninstall_cases();
    test_random_traffic(480, 0, 0);
    test_random_traffic(480, 47, 0);
    test_random_traffic(480, 0, 47);
    test_random_traffic(480, 6, 6);

    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
